>>> sv/pidpd_pkg.sv
package pidpd_pkg;

    // Limit registers are always 31 bits, whatever the data width
    localparam int LIMIT_W   = 31;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE           = 3'd0,
        CFG_GAIN_P         = 3'd1,
        CFG_GAIN_I         = 3'd2,
        CFG_GAIN_D         = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } mode_t;

    // Per-stage flow control: advance loads the stage, valid_in is what moves in
    typedef struct packed {
        logic advance;
        logic valid_in;
    } stage_ctl_t;

endpackage

>>> sv/pidpd_if.sv
interface pidpd_sample_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] feedback;
    logic signed [DATA_WIDTH-1:0] setpoint;

    modport source (output valid, output feedback, output setpoint, input ready);
    modport sink   (input valid, input feedback, input setpoint, output ready);
endinterface

interface pidpd_drive_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

>>> sv/pidpd_err.sv
module pidpd_err #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pidpd_pkg::stage_ctl_t        ctl,
    input  pidpd_pkg::mode_t             mode,
    input  logic signed [DATA_WIDTH-1:0] feedback,
    input  logic signed [DATA_WIDTH-1:0] setpoint,
    output logic                         valid,
    output logic signed [DATA_WIDTH-1:0] e0,
    output logic signed [DATA_WIDTH-1:0] xp,
    output logic signed [DATA_WIDTH-1:0] xd
);

    localparam int W = DATA_WIDTH;
    localparam logic signed [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_w(input logic signed [W+2:0] v);
        if (v[W+2:W-1] == {4{v[W+2]}})
            return v[W-1:0];
        else if (v[W+2])
            return DMIN;
        else
            return DMAX;
    endfunction

    logic                 valid_reg, valid_next;
    logic signed [W-1:0]  e1_reg, e1_next;
    logic signed [W-1:0]  e2_reg, e2_next;
    logic signed [W-1:0]  e0_reg, e0_next;
    logic signed [W-1:0]  xp_reg, xp_next;
    logic signed [W-1:0]  xd_reg, xd_next;
    logic signed [W+2:0]  raw_e0, raw_d1, raw_d2;
    logic signed [W-1:0]  err, d1, d2;
    logic                 accept;

    assign accept = ctl.advance && ctl.valid_in;

    always_comb
    begin
        raw_e0 = (W+3)'(setpoint) - (W+3)'(feedback);
        err    = sat_w(raw_e0);
        raw_d1 = (W+3)'(err) - (W+3)'(e1_reg);
        d1     = sat_w(raw_d1);
        raw_d2 = (W+3)'(err) - ((W+3)'(e1_reg) <<< 1) + (W+3)'(e2_reg);
        d2     = sat_w(raw_d2);
    end

    always_comb
    begin
        valid_next = ctl.advance ? ctl.valid_in : valid_reg;
        e1_next    = accept ? err : e1_reg;
        e2_next    = accept ? e1_reg : e2_reg;
        e0_next    = e0_reg;
        xp_next    = xp_reg;
        xd_next    = xd_reg;
        if (accept)
        begin
            e0_next = err;
            // operand selection for the P and D multipliers
            case (mode)
                pidpd_pkg::MODE_POSITIONAL:
                begin
                    xp_next = err;
                    xd_next = d1;
                end
                pidpd_pkg::MODE_INCREMENTAL:
                begin
                    xp_next = d1;
                    xd_next = d2;
                end
                default:
                begin
                    xp_next = err;
                    xd_next = d1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            e1_reg    <= '0;
            e2_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            e1_reg    <= e1_next;
            e2_reg    <= e2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        xp_reg <= xp_next;
        xd_reg <= xd_next;
    end

    assign valid = valid_reg;
    assign e0    = e0_reg;
    assign xp    = xp_reg;
    assign xd    = xd_reg;

endmodule

>>> sv/pidpd_mul.sv
module pidpd_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pidpd_pkg::stage_ctl_t        ctl,
    input  logic signed [DATA_WIDTH-1:0] gain_p,
    input  logic signed [DATA_WIDTH-1:0] gain_i,
    input  logic signed [DATA_WIDTH-1:0] gain_d,
    input  logic signed [DATA_WIDTH-1:0] e0,
    input  logic signed [DATA_WIDTH-1:0] xp,
    input  logic signed [DATA_WIDTH-1:0] xd,
    output logic                         valid,
    output logic signed [DATA_WIDTH-1:0] q_p,
    output logic signed [DATA_WIDTH-1:0] q_i,
    output logic signed [DATA_WIDTH-1:0] q_d
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam logic signed [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};

    // Exact product, floor shift by the fraction bits, saturate to W
    function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] g,
                                                 input logic signed [W-1:0] x);
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] sh;
        prod = PW'(g) * PW'(x);
        sh   = prod >>> FRAC_BITS;
        if (sh[PW-1:W-1] == {(W+1){sh[PW-1]}})
            return sh[W-1:0];
        else if (sh[PW-1])
            return DMIN;
        else
            return DMAX;
    endfunction

    logic                valid_reg, valid_next;
    logic signed [W-1:0] qp_reg, qp_next;
    logic signed [W-1:0] qi_reg, qi_next;
    logic signed [W-1:0] qd_reg, qd_next;

    always_comb
    begin
        valid_next = ctl.advance ? ctl.valid_in : valid_reg;
        qp_next    = qp_reg;
        qi_next    = qi_reg;
        qd_next    = qd_reg;
        if (ctl.advance && ctl.valid_in)
        begin
            qp_next = qmul(gain_p, xp);
            qi_next = qmul(gain_i, e0);
            qd_next = qmul(gain_d, xd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        qp_reg <= qp_next;
        qi_reg <= qi_next;
        qd_reg <= qd_next;
    end

    assign valid = valid_reg;
    assign q_p   = qp_reg;
    assign q_i   = qi_reg;
    assign q_d   = qd_reg;

endmodule

>>> sv/pidpd_acc.sv
module pidpd_acc #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pidpd_pkg::stage_ctl_t               ctl,
    input  pidpd_pkg::mode_t                    mode,
    input  logic [pidpd_pkg::LIMIT_W-1:0]       output_limit,
    input  logic [pidpd_pkg::LIMIT_W-1:0]       integral_limit,
    input  logic signed [DATA_WIDTH-1:0]        q_p,
    input  logic signed [DATA_WIDTH-1:0]        q_i,
    input  logic signed [DATA_WIDTH-1:0]        q_d,
    output logic                                valid,
    output logic signed [DATA_WIDTH-1:0]        drive
);

    localparam int W   = DATA_WIDTH;
    // last output is bounded by the 31-bit limit, so it may need more than W bits
    localparam int LOW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int SW  = LOW + 2;
    localparam logic signed [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [LOW-1:0] clamp_lim(
        input logic signed [SW-1:0]             v,
        input logic [pidpd_pkg::LIMIT_W-1:0]    lim
    );
        logic signed [SW-1:0] m;
        m = SW'(lim);
        if (v > m)
            return LOW'(m);
        else if (v < -m)
            return LOW'(-m);
        else
            return LOW'(v);
    endfunction

    logic                  valid_reg, valid_next;
    logic signed [W-1:0]   integ_reg, integ_next;
    logic signed [LOW-1:0] last_reg, last_next;
    logic signed [W-1:0]   drive_reg, drive_next;
    logic signed [W:0]     integ_sum;
    logic signed [W-1:0]   integ_sat;
    logic signed [LOW-1:0] integ_clamped;
    logic signed [W-1:0]   integ_pos;
    logic signed [SW-1:0]  pos_sum, inc_sum;
    logic signed [LOW-1:0] y;
    logic                  load;

    assign load = ctl.advance && ctl.valid_in;

    always_comb
    begin
        integ_sum = (W+1)'(integ_reg) + (W+1)'(q_i);
        if (integ_sum[W] == integ_sum[W-1])
            integ_sat = integ_sum[W-1:0];
        else if (integ_sum[W])
            integ_sat = DMIN;
        else
            integ_sat = DMAX;
        integ_clamped = clamp_lim(SW'(integ_sat), integral_limit);
        integ_pos     = integ_clamped[W-1:0];
        pos_sum       = SW'(q_p) + SW'(integ_pos) + SW'(q_d);
        inc_sum       = SW'(last_reg) + SW'(q_p) + SW'(q_i) + SW'(q_d);
    end

    always_comb
    begin
        valid_next = ctl.advance ? ctl.valid_in : valid_reg;
        integ_next = integ_reg;
        last_next  = last_reg;
        drive_next = drive_reg;
        y          = '0;
        if (load)
        begin
            case (mode)
                pidpd_pkg::MODE_POSITIONAL:
                begin
                    integ_next = integ_pos;
                    y          = clamp_lim(pos_sum, output_limit);
                end
                pidpd_pkg::MODE_INCREMENTAL:
                begin
                    // integral register holds the latest increment in this mode
                    integ_next = q_i;
                    y          = clamp_lim(inc_sum, output_limit);
                end
                default:
                begin
                    integ_next = integ_pos;
                    y          = clamp_lim(pos_sum, output_limit);
                end
            endcase
            last_next  = y;
            drive_next = y[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            integ_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            integ_reg <= integ_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg <= drive_next;
    end

    assign valid = valid_reg;
    assign drive = drive_reg;

endmodule

>>> sv/pid_position_delta_regulator.sv
// A sample passes the error, product and accumulate/result stages to the drive
// output. Throughput: one sample per cycle unless drives.ready stalls it;
// the integral/last-output loop closes within the accumulate stage and the three
// gain multipliers sit in their own stage.
// Reset (rst_n, async, active low) clears all config registers, error history,
// integral and last output to zero and empties the pipeline.
module pid_position_delta_regulator #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [pidpd_pkg::CFG_IDX_W-1:0]            cfg_idx,
    input  logic [((DATA_WIDTH > pidpd_pkg::LIMIT_W) ?
                   DATA_WIDTH : pidpd_pkg::LIMIT_W)-1:0] cfg_wdata,
    pidpd_sample_if.sink                               samples,
    pidpd_drive_if.source                              drives
);

    localparam int W = DATA_WIDTH;

    pidpd_pkg::mode_t               mode_reg;
    logic signed [W-1:0]            gain_p_reg;
    logic signed [W-1:0]            gain_i_reg;
    logic signed [W-1:0]            gain_d_reg;
    logic [pidpd_pkg::LIMIT_W-1:0]  output_limit_reg;
    logic [pidpd_pkg::LIMIT_W-1:0]  integral_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= pidpd_pkg::MODE_POSITIONAL;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            output_limit_reg   <= '0;
            integral_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (pidpd_pkg::cfg_idx_t'(cfg_idx))
                pidpd_pkg::CFG_MODE:           mode_reg <= pidpd_pkg::mode_t'(cfg_wdata[0]);
                pidpd_pkg::CFG_GAIN_P:         gain_p_reg <= cfg_wdata[W-1:0];
                pidpd_pkg::CFG_GAIN_I:         gain_i_reg <= cfg_wdata[W-1:0];
                pidpd_pkg::CFG_GAIN_D:         gain_d_reg <= cfg_wdata[W-1:0];
                pidpd_pkg::CFG_OUTPUT_LIMIT:
                    output_limit_reg <= cfg_wdata[pidpd_pkg::LIMIT_W-1:0];
                pidpd_pkg::CFG_INTEGRAL_LIMIT:
                    integral_limit_reg <= cfg_wdata[pidpd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Stall chain: a stage loads when it is empty or its successor loads
    logic                  err_valid, mul_valid, acc_valid;
    logic                  en_acc, en_mul, en_err;
    pidpd_pkg::stage_ctl_t err_ctl, mul_ctl, acc_ctl;
    logic signed [W-1:0]   e0, xp, xd;
    logic signed [W-1:0]   q_p, q_i, q_d;

    assign en_acc = !acc_valid || drives.ready;
    assign en_mul = !mul_valid || en_acc;
    assign en_err = !err_valid || en_mul;

    assign samples.ready = en_err;

    assign err_ctl = '{advance: en_err, valid_in: samples.valid};
    assign mul_ctl = '{advance: en_mul, valid_in: err_valid};
    assign acc_ctl = '{advance: en_acc, valid_in: mul_valid};

    pidpd_err #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_err (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (err_ctl),
        .mode     (mode_reg),
        .feedback (samples.feedback),
        .setpoint (samples.setpoint),
        .valid    (err_valid),
        .e0       (e0),
        .xp       (xp),
        .xd       (xd)
    );

    pidpd_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .gain_p (gain_p_reg),
        .gain_i (gain_i_reg),
        .gain_d (gain_d_reg),
        .e0     (e0),
        .xp     (xp),
        .xd     (xd),
        .valid  (mul_valid),
        .q_p    (q_p),
        .q_i    (q_i),
        .q_d    (q_d)
    );

    pidpd_acc #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_acc (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (acc_ctl),
        .mode           (mode_reg),
        .output_limit   (output_limit_reg),
        .integral_limit (integral_limit_reg),
        .q_p            (q_p),
        .q_i            (q_i),
        .q_d            (q_d),
        .valid          (acc_valid),
        .drive          (drives.drive)
    );

    assign drives.valid = acc_valid;

endmodule
